// ===== sv/irct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package irct_pkg;

    typedef enum logic [3:0] {
        PH_LINE_START   = 4'd0,
        PH_KEY          = 4'd1,
        PH_VALUE        = 4'd2,
        PH_AFTER_TAGS   = 4'd3,
        PH_PREFIX_START = 4'd4,
        PH_PREFIX       = 4'd5,
        PH_CMD_START    = 4'd6,
        PH_CMD_NUM      = 4'd7,
        PH_CMD_ALPHA    = 4'd8,
        PH_PARAM_START  = 4'd9,
        PH_MIDDLE       = 4'd10,
        PH_LAST_START   = 4'd11,
        PH_TRAILING     = 4'd12,
        PH_CR_SEEN      = 4'd13,
        PH_ERROR        = 4'd14
    } phase_t;

    localparam logic [1:0] EV_DATA      = 2'd0;
    localparam logic [1:0] EV_FIELD_END = 2'd1;
    localparam logic [1:0] EV_LINE_END  = 2'd2;

    localparam logic [2:0] FK_KEY    = 3'd0;
    localparam logic [2:0] FK_VALUE  = 3'd1;
    localparam logic [2:0] FK_PREFIX = 3'd2;
    localparam logic [2:0] FK_CMD    = 3'd3;
    localparam logic [2:0] FK_MIDDLE = 3'd4;
    localparam logic [2:0] FK_TRAIL  = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EMPTY      = 3'd1;
    localparam logic [2:0] ST_BAD_TAG    = 3'd2;
    localparam logic [2:0] ST_BAD_ESCAPE = 3'd3;
    localparam logic [2:0] ST_BAD_PREFIX = 3'd4;
    localparam logic [2:0] ST_BAD_CMD    = 3'd5;
    localparam logic [2:0] ST_BAD_PARAM  = 3'd6;
    localparam logic [2:0] ST_BAD_ENDING = 3'd7;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;

    localparam logic [1:0] NUM_DIGITS = 2'd3;
    localparam logic [9:0] TEN        = 10'd10;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [2:0] field_kind;
        logic [3:0] param_number;
        logic [7:0] data_out;
        logic       key_without_value;
        logic       is_numeric;
        logic [9:0] reply_number;
        logic [2:0] line_status;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/irct_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module irct_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] line_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= line_byte;
        end
    end

endmodule

`default_nettype wire

// ===== sv/irct_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module irct_core #(
    parameter int MAX_PARAMS = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        line_byte,
    output logic              res_emit,
    output irct_pkg::result_t res
);
    import irct_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [2:0] err_code_reg;
    logic [2:0] err_code_next;
    logic [3:0] pc_reg;
    logic [3:0] pc_next;
    logic [1:0] vendor_reg;
    logic [1:0] vendor_next;
    logic       nonempty_reg;
    logic       nonempty_next;
    logic       esc_reg;
    logic       esc_next;
    logic [1:0] digit_reg;
    logic [1:0] digit_next;
    logic [9:0] acc_reg;
    logic [9:0] acc_next;

    logic       is_let;
    logic       is_dig;
    logic       is_lf;
    logic       is_cr;
    logic       is_sp;
    logic       key_bad;
    logic       esc_ok;
    logic [7:0] esc_char;
    logic [3:0] pc_inc;
    phase_t     param_phase;
    logic [3:0] digit_val;
    logic       fail_now;
    logic [2:0] fail_code;

    assign is_let    = line_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    assign is_dig    = line_byte inside {[8'h30:8'h39]};
    assign is_lf     = (line_byte == CH_LF);
    assign is_cr     = (line_byte == CH_CR);
    assign is_sp     = (line_byte == CH_SP);
    assign key_bad   = !nonempty_reg || (vendor_reg[1] && !vendor_reg[0]);
    assign pc_inc    = pc_reg + 4'd1;
    assign digit_val = 4'(line_byte - CH_ZERO);
    assign param_phase = (32'(pc_inc) >= MAX_PARAMS) ? PH_LAST_START : PH_PARAM_START;

    always_comb
    begin
        esc_ok   = 1'b1;
        esc_char = line_byte;
        case (line_byte)
            CH_COLON:  esc_char = CH_SEMI;
            CH_S:      esc_char = CH_SP;
            CH_BSLASH: esc_char = CH_BSLASH;
            CH_R:      esc_char = CH_CR;
            CH_N:      esc_char = CH_LF;
            default:   esc_ok   = 1'b0;
        endcase
    end

    // Error detection for the current byte; the first error of a line is kept.
    always_comb
    begin
        fail_now  = 1'b0;
        fail_code = ST_OK;
        case (phase_reg)
            PH_LINE_START:
            begin
                if (is_cr)
                begin
                    fail_now  = 1'b1;
                    fail_code = ST_EMPTY;
                end
                else if (!(line_byte inside {CH_AT, CH_COLON}) && !is_let && !is_dig)
                begin
                    fail_now  = 1'b1;
                    fail_code = ST_BAD_CMD;
                end
            end
            PH_KEY:
            begin
                fail_code = ST_BAD_TAG;
                if (is_let || is_dig || line_byte == CH_DASH)
                begin
                    fail_now = 1'b0;
                end
                else if (line_byte inside {CH_DOT, CH_COLON, CH_SLASH})
                begin
                    fail_now = vendor_reg[0];
                end
                else if (line_byte inside {CH_EQ, CH_SEMI, CH_SP})
                begin
                    fail_now = key_bad;
                end
                else
                begin
                    fail_now = 1'b1;
                end
            end
            PH_VALUE:
            begin
                if (esc_reg)
                begin
                    fail_now  = !esc_ok;
                    fail_code = ST_BAD_ESCAPE;
                end
                else if (line_byte inside {CH_NUL, CH_CR})
                begin
                    fail_now  = 1'b1;
                    fail_code = ST_BAD_TAG;
                end
            end
            PH_AFTER_TAGS:
            begin
                if (line_byte != CH_COLON && !is_let && !is_dig)
                begin
                    fail_now  = 1'b1;
                    fail_code = ST_BAD_CMD;
                end
            end
            PH_PREFIX_START:
            begin
                fail_now  = is_sp || is_cr;
                fail_code = ST_BAD_PREFIX;
            end
            PH_PREFIX:
            begin
                fail_now  = is_cr;
                fail_code = ST_BAD_PREFIX;
            end
            PH_CMD_START:
            begin
                fail_now  = !is_let && !is_dig;
                fail_code = ST_BAD_CMD;
            end
            PH_CMD_NUM:
            begin
                if (digit_reg < NUM_DIGITS)
                begin
                    fail_now  = !is_dig;
                    fail_code = ST_BAD_CMD;
                end
                else
                begin
                    fail_now  = !is_sp && !is_cr;
                    fail_code = ST_BAD_ENDING;
                end
            end
            PH_CMD_ALPHA:
            begin
                fail_now  = !is_let && !is_sp && !is_cr;
                fail_code = ST_BAD_ENDING;
            end
            PH_PARAM_START:
            begin
                fail_now  = line_byte inside {CH_NUL, CH_CR, CH_SP};
                fail_code = ST_BAD_PARAM;
            end
            PH_MIDDLE, PH_LAST_START, PH_TRAILING:
            begin
                fail_now  = (line_byte == CH_NUL);
                fail_code = ST_BAD_PARAM;
            end
            PH_CR_SEEN:
            begin
                fail_now  = 1'b1;
                fail_code = ST_BAD_ENDING;
            end
            default:
            begin
                fail_now  = 1'b0;
                fail_code = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        err_code_next = err_code_reg;
        pc_next       = pc_reg;
        vendor_next   = vendor_reg;
        nonempty_next = nonempty_reg;
        esc_next      = esc_reg;
        digit_next    = digit_reg;
        acc_next      = acc_reg;
        if (step_en)
        begin
            if (is_lf)
            begin
                phase_next    = PH_LINE_START;
                err_code_next = ST_OK;
                pc_next       = '0;
                vendor_next   = '0;
                nonempty_next = 1'b0;
                esc_next      = 1'b0;
                digit_next    = '0;
                acc_next      = '0;
            end
            else if (phase_reg == PH_ERROR)
            begin
                phase_next = PH_ERROR;
            end
            else if (fail_now)
            begin
                phase_next    = PH_ERROR;
                err_code_next = fail_code;
                esc_next      = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_LINE_START, PH_AFTER_TAGS, PH_CMD_START:
                    begin
                        if (line_byte == CH_AT && phase_reg == PH_LINE_START)
                        begin
                            phase_next    = PH_KEY;
                            nonempty_next = 1'b0;
                            vendor_next   = '0;
                        end
                        else if (line_byte == CH_COLON)
                        begin
                            phase_next = PH_PREFIX_START;
                        end
                        else if (is_dig)
                        begin
                            phase_next = PH_CMD_NUM;
                            digit_next = 2'd1;
                            acc_next   = 10'(digit_val);
                        end
                        else
                        begin
                            phase_next = PH_CMD_ALPHA;
                        end
                    end
                    PH_KEY:
                    begin
                        if (line_byte == CH_EQ)
                        begin
                            phase_next = PH_VALUE;
                            esc_next   = 1'b0;
                        end
                        else if (line_byte inside {CH_SEMI, CH_SP})
                        begin
                            phase_next    = is_sp ? PH_AFTER_TAGS : PH_KEY;
                            nonempty_next = 1'b0;
                            vendor_next   = '0;
                        end
                        else
                        begin
                            nonempty_next = 1'b1;
                            if (line_byte == CH_SLASH)
                            begin
                                vendor_next = vendor_reg | 2'b01;
                            end
                            else if (line_byte inside {CH_DOT, CH_COLON})
                            begin
                                vendor_next = vendor_reg | 2'b10;
                            end
                        end
                    end
                    PH_VALUE:
                    begin
                        if (esc_reg)
                        begin
                            esc_next = 1'b0;
                        end
                        else if (line_byte == CH_BSLASH)
                        begin
                            esc_next = 1'b1;
                        end
                        else if (line_byte inside {CH_SEMI, CH_SP})
                        begin
                            phase_next    = is_sp ? PH_AFTER_TAGS : PH_KEY;
                            nonempty_next = 1'b0;
                            vendor_next   = '0;
                        end
                    end
                    PH_PREFIX_START:
                    begin
                        phase_next = PH_PREFIX;
                    end
                    PH_PREFIX:
                    begin
                        if (is_sp)
                        begin
                            phase_next = PH_CMD_START;
                        end
                    end
                    PH_CMD_NUM:
                    begin
                        if (digit_reg < NUM_DIGITS)
                        begin
                            digit_next = digit_reg + 2'd1;
                            acc_next   = 10'(acc_reg * TEN + 10'(digit_val));
                        end
                        else if (is_sp)
                        begin
                            pc_next    = pc_inc;
                            phase_next = param_phase;
                        end
                        else
                        begin
                            phase_next = PH_CR_SEEN;
                        end
                    end
                    PH_CMD_ALPHA, PH_MIDDLE:
                    begin
                        if (is_sp)
                        begin
                            pc_next    = pc_inc;
                            phase_next = param_phase;
                        end
                        else if (is_cr)
                        begin
                            phase_next = PH_CR_SEEN;
                        end
                    end
                    PH_PARAM_START:
                    begin
                        phase_next = (line_byte == CH_COLON) ? PH_TRAILING : PH_MIDDLE;
                    end
                    PH_LAST_START, PH_TRAILING:
                    begin
                        phase_next = is_cr ? PH_CR_SEEN : PH_TRAILING;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res_emit = 1'b0;
        res      = '0;
        if (is_lf)
        begin
            res_emit       = 1'b1;
            res.event_kind = EV_LINE_END;
            res.last       = 1'b1;
            if (phase_reg == PH_ERROR)
            begin
                res.line_status = err_code_reg;
            end
            else if (phase_reg == PH_CR_SEEN)
            begin
                res.line_status = ST_OK;
            end
            else if (phase_reg == PH_LINE_START)
            begin
                res.line_status = ST_EMPTY;
            end
            else
            begin
                res.line_status = ST_BAD_ENDING;
            end
        end
        else if (phase_reg != PH_ERROR && !fail_now)
        begin
            res.data_out = line_byte;
            case (phase_reg)
                PH_LINE_START, PH_AFTER_TAGS, PH_CMD_START:
                begin
                    res_emit       = is_let || is_dig;
                    res.field_kind = FK_CMD;
                end
                PH_KEY:
                begin
                    res_emit       = 1'b1;
                    res.field_kind = FK_KEY;
                    if (line_byte inside {CH_EQ, CH_SEMI, CH_SP})
                    begin
                        res.event_kind        = EV_FIELD_END;
                        res.data_out          = '0;
                        res.key_without_value = (line_byte != CH_EQ);
                    end
                end
                PH_VALUE:
                begin
                    res.field_kind = FK_VALUE;
                    if (esc_reg)
                    begin
                        res_emit     = 1'b1;
                        res.data_out = esc_char;
                    end
                    else if (line_byte inside {CH_SEMI, CH_SP})
                    begin
                        res_emit       = 1'b1;
                        res.event_kind = EV_FIELD_END;
                        res.data_out   = '0;
                    end
                    else
                    begin
                        res_emit = (line_byte != CH_BSLASH);
                    end
                end
                PH_PREFIX_START, PH_PREFIX:
                begin
                    res_emit       = 1'b1;
                    res.field_kind = FK_PREFIX;
                    if (is_sp)
                    begin
                        res.event_kind = EV_FIELD_END;
                        res.data_out   = '0;
                    end
                end
                PH_CMD_NUM:
                begin
                    res_emit       = 1'b1;
                    res.field_kind = FK_CMD;
                    if (digit_reg >= NUM_DIGITS)
                    begin
                        res.event_kind   = EV_FIELD_END;
                        res.data_out     = '0;
                        res.is_numeric   = 1'b1;
                        res.reply_number = acc_reg;
                    end
                end
                PH_CMD_ALPHA:
                begin
                    res_emit       = 1'b1;
                    res.field_kind = FK_CMD;
                    if (!is_let)
                    begin
                        res.event_kind = EV_FIELD_END;
                        res.data_out   = '0;
                    end
                end
                PH_PARAM_START:
                begin
                    res_emit         = (line_byte != CH_COLON);
                    res.field_kind   = FK_MIDDLE;
                    res.param_number = pc_reg;
                end
                PH_MIDDLE:
                begin
                    res_emit         = 1'b1;
                    res.field_kind   = FK_MIDDLE;
                    res.param_number = pc_reg;
                    if (is_sp || is_cr)
                    begin
                        res.event_kind = EV_FIELD_END;
                        res.data_out   = '0;
                    end
                end
                PH_LAST_START, PH_TRAILING:
                begin
                    res_emit         = !(phase_reg == PH_LAST_START && line_byte == CH_COLON);
                    res.field_kind   = FK_TRAIL;
                    res.param_number = pc_reg;
                    if (is_cr)
                    begin
                        res.event_kind = EV_FIELD_END;
                        res.data_out   = '0;
                    end
                end
                default:
                begin
                    res_emit = 1'b0;
                end
            endcase
        end
        if (!res_emit)
        begin
            res = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LINE_START;
            err_code_reg <= ST_OK;
            pc_reg       <= '0;
            vendor_reg   <= '0;
            nonempty_reg <= 1'b0;
            esc_reg      <= 1'b0;
            digit_reg    <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            err_code_reg <= err_code_next;
            pc_reg       <= pc_next;
            vendor_reg   <= vendor_next;
            nonempty_reg <= nonempty_next;
            esc_reg      <= esc_next;
            digit_reg    <= digit_next;
            acc_reg      <= acc_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/irc_line_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid / in_stall  line_byte
// output    out_valid/ out_stall event_kind, field_kind, param_number, data_out,
//                                key_without_value, is_numeric, reply_number,
//                                line_status, last
//
// One byte per cycle is sustained while the output is not stalled: a byte is held
// in the input register and is tokenized into the result register as it advances.
// Reset clears the line state to the start of a line and empties both registers.
// A stalled output holds its word, and the input register then stalls the input.

module irc_line_tokenizer #(
    parameter int MAX_PARAMS = 15
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] line_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] event_kind,
    output logic [2:0] field_kind,
    output logic [3:0] param_number,
    output logic [7:0] data_out,
    output logic       key_without_value,
    output logic       is_numeric,
    output logic [9:0] reply_number,
    output logic [2:0] line_status,
    output logic       last
);
    import irct_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       advance;
    logic       res_emit;
    result_t    res;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_res_reg;

    assign advance = byte_valid && (!out_valid_reg || !out_stall);

    irct_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .line_byte  (line_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    irct_core #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .line_byte (byte_data),
        .res_emit  (res_emit),
        .res       (res)
    );

    assign out_valid_next = advance ? res_emit : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_emit)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign event_kind        = out_res_reg.event_kind;
    assign field_kind        = out_res_reg.field_kind;
    assign param_number      = out_res_reg.param_number;
    assign data_out          = out_res_reg.data_out;
    assign key_without_value = out_res_reg.key_without_value;
    assign is_numeric        = out_res_reg.is_numeric;
    assign reply_number      = out_res_reg.reply_number;
    assign line_status       = out_res_reg.line_status;
    assign last              = out_res_reg.last;

    // A line feed always closes the line with a line-end word.
    a_lf_closes_line: assert property (@(posedge clk) disable iff (!rst_n)
        advance && byte_data == CH_LF |=> out_valid && last && event_kind == EV_LINE_END)
        else $error("line feed did not produce a line-end word");

    // The input only stalls behind a held output word.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output word");

    // Only the line-end word carries a status.
    a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> line_status == ST_OK && event_kind != EV_LINE_END)
        else $error("status or line end on a word that is not last");

endmodule

`default_nettype wire
